// ===== design/ffpa_pkg.sv =====
// Package for the first-fit pool allocator: sizes, status codes, field types.
// No dependencies.
`timescale 1ns / 1ps
package ffpa_pkg;
    localparam int POOL_BYTES  = 65536;
    localparam int MAX_REQUEST = 16383;
    localparam int HDR_BYTES   = 2;
    localparam int WORD_BITS   = 16;
    localparam int WORDS       = POOL_BYTES / WORD_BITS;
    localparam int WAW         = $clog2(WORDS);
    localparam int BAW         = $clog2(POOL_BYTES);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [13:0] request_size;
        logic [15:0] free_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_address;
        logic [16:0] free_bytes;
        logic [16:0] largest_free;
        logic [16:0] smallest_free;
    } t_rsp;
endpackage

// ===== design/ffpa_if.sv =====
// Valid/ready channel interfaces for the allocator.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps
interface ffpa_req_if;
    logic             valid;
    logic             ready;
    ffpa_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffpa_rsp_if;
    logic             valid;
    logic             ready;
    ffpa_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/first_fit_pool_allocator.sv =====
// First-fit pool allocator, top level.
// Depends on ffpa_pkg and ffpa_if.
//
// Usage: commands arrive on i_req (valid/ready, one transaction per command),
// results leave on o_rsp, one per command. An allocate scans the occupancy
// bitmap from offset 0, reading then testing each byte, skipping a
// whole block at its start byte; a byte bitmap lives in one memory, block
// starts and lengths in a second. After the command a statistics sweep reads
// the bitmap sixteen bytes per cycle to build free total, largest and
// smallest run.
// Sequence: an allocate scans, then marks the block, then runs the sweep and
// the result; a free checks the block table, clears the block, then runs the
// sweep; a rejected command goes straight to the sweep. One command at a time.
// Reset: a clearing pass writes zero to every block-table entry and bitmap
// word, one byte position per cycle, during which i_req.ready stays low.
// Stall: the result sits in an output register until o_rsp.ready; the next
// command is taken only once that register drains.
`timescale 1ns / 1ps
module first_fit_pool_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffpa_req_if.sink   i_req,
    ffpa_rsp_if.source o_rsp
);
    import ffpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN, S_MARK_RD, S_MARK, S_FREE_RD,
        S_FREE_CHK, S_UNMARK_RD, S_UNMARK, S_STAT_RD, S_STAT, S_OUT
    } t_state;

    // bitmap memory: 16 bytes per word
    logic [WORD_BITS-1:0] occ_mem [WORDS];
    logic [WORD_BITS-1:0] r_occ_q;
    // block start flag and length, one entry per byte
    logic [14:0]          blk_mem [POOL_BYTES];
    logic [14:0]          r_blk_q;

    t_state        r_state;
    t_req          r_req;
    t_rsp          r_rsp;
    logic          r_out_v;
    logic [BAW:0]  r_pos;      // byte position, may reach POOL_BYTES
    logic [BAW:0]  r_start;
    logic [BAW:0]  r_end;      // one past the last byte
    logic [14:0]   r_need;
    logic [14:0]   r_run;
    logic [16:0]   r_tot, r_big, r_small, r_srun;
    logic [1:0]    r_st;
    logic [15:0]   r_baddr;

    logic          occ_we;
    logic [WAW-1:0] occ_wa;
    logic [WORD_BITS-1:0] occ_wd;
    logic          blk_we;
    logic [BAW-1:0] blk_wa;
    logic [14:0]   blk_wd;
    logic [WAW-1:0] occ_ra;
    logic [BAW-1:0] blk_ra;

    always_ff @(posedge i_clk) begin
        if (occ_we) occ_mem[occ_wa] <= occ_wd;
        r_occ_q <= occ_mem[occ_ra];
        if (blk_we) blk_mem[blk_wa] <= blk_wd;
        r_blk_q <= blk_mem[blk_ra];
    end

    logic [3:0] bit_sel;
    logic       cur_occ;
    logic [16:0] run_ext;
    logic [4:0]  word_free;
    logic [16:0] cand_run;
    logic [16:0] s_run, s_big, s_small;
    logic [4:0]  w_cnt, w_lead, w_in_big, w_in_small;
    logic        w_seen;
    logic [16:0] closed_run;

    assign bit_sel = r_pos[3:0];
    assign cur_occ = r_occ_q[bit_sel];
    assign run_ext = {2'b0, r_run} + 17'd1;

    // runs inside one word: leading free bits, inner runs, trailing free bits
    always_comb begin
        w_cnt = 5'd0; w_lead = 5'd0; w_in_big = 5'd0; w_in_small = 5'd0; w_seen = 1'b0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (!r_occ_q[b]) begin
                w_cnt = w_cnt + 5'd1;
            end else begin
                if (!w_seen) begin
                    w_lead = w_cnt;
                end else if (w_cnt != 5'd0) begin
                    if (w_cnt > w_in_big) w_in_big = w_cnt;
                    if (w_in_small == 5'd0 || w_cnt < w_in_small) w_in_small = w_cnt;
                end
                w_seen = 1'b1;
                w_cnt  = 5'd0;
            end
        end
    end

    // fold the word into the running statistics
    always_comb begin
        closed_run = r_srun + {12'd0, w_lead};
        s_big      = r_big;
        s_small    = r_small;
        s_run      = r_srun + {12'd0, w_cnt};
        if (w_seen) begin
            s_run = {12'd0, w_cnt};
            if (closed_run != 17'd0) begin
                if (closed_run > s_big) s_big = closed_run;
                if (s_small == 17'd0 || closed_run < s_small) s_small = closed_run;
            end
            if (w_in_big != 5'd0) begin
                if ({12'd0, w_in_big} > s_big) s_big = {12'd0, w_in_big};
                if (s_small == 17'd0 || {12'd0, w_in_small} < s_small)
                    s_small = {12'd0, w_in_small};
            end
        end
    end
    always_comb begin
        word_free = 5'd0;
        for (int b = 0; b < WORD_BITS; b++) word_free = word_free + {4'd0, ~r_occ_q[b]};
    end
    assign cand_run = r_srun;

    assign i_req.ready = (r_state == S_IDLE) && !r_out_v;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.data  = r_rsp;

    logic [15:0] cur_mask;
    always_comb begin
        cur_mask = r_occ_q;
        cur_mask[bit_sel] = (r_state == S_MARK);
    end

    always_comb begin
        occ_we = 1'b0; occ_wa = r_pos[BAW-1:4]; occ_wd = cur_mask;
        blk_we = 1'b0; blk_wa = r_start[BAW-1:0]; blk_wd = 15'd0;
        occ_ra = r_pos[BAW-1:4]; blk_ra = r_pos[BAW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                occ_we = 1'b1; occ_wd = '0;
                blk_we = 1'b1; blk_wa = r_pos[BAW-1:0];
            end
            S_MARK, S_UNMARK: occ_we = 1'b1;
            S_FREE_RD: blk_ra = r_req.free_address[BAW-1:0] - BAW'(HDR_BYTES);
            // prefetch the next word while the current one is folded in
            S_STAT: occ_ra = r_pos[BAW-1:4] + WAW'(1);
            default: ;
        endcase
        if (r_state == S_MARK && r_pos == r_start) begin
            blk_we = 1'b1; blk_wd = {1'b1, r_req.request_size};
        end
        if (r_state == S_UNMARK && r_pos == r_start) begin
            blk_we = 1'b1; blk_wd = 15'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pos   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    // one block-table entry per cycle; bitmap words cleared on the way
                    if (r_pos[BAW-1:0] == '1) begin
                        r_state <= S_IDLE;
                        r_pos   <= '0;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_IDLE: if (i_req.valid && i_req.ready) begin
                    r_req   <= i_req.data;
                    r_baddr <= '0;
                    r_pos   <= '0;
                    r_run   <= '0;
                    r_need  <= {1'b0, i_req.data.request_size} + 15'(HDR_BYTES);
                    if (i_req.data.cmd == CMD_FREE) begin
                        if (i_req.data.free_address < 16'(HDR_BYTES)) begin
                            r_st <= ST_ILLEGAL; r_state <= S_STAT_RD;
                        end else r_state <= S_FREE_RD;
                    end else if (i_req.data.request_size == 14'd0 ||
                                 32'(i_req.data.request_size) > MAX_REQUEST) begin
                        r_st <= ST_OOM; r_state <= S_STAT_RD;
                    end else r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (r_pos[BAW]) begin
                        r_st <= ST_OOM; r_pos <= '0; r_state <= S_STAT_RD;
                    end else r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_state <= S_SCAN_RD;
                    if (cur_occ) begin
                        r_run <= '0;
                        if (r_blk_q[14])
                            r_pos <= r_pos + (BAW+1)'(r_blk_q[13:0]) + (BAW+1)'(HDR_BYTES);
                        else
                            r_pos <= r_pos + 1'b1;
                    end else if (run_ext[14:0] == r_need) begin
                        r_start <= r_pos + 1'b1 - (BAW+1)'(r_need);
                        r_end   <= r_pos + 1'b1;
                        r_pos   <= r_pos + 1'b1 - (BAW+1)'(r_need);
                        r_baddr <= 16'(r_pos + 1'b1 - (BAW+1)'(r_need) + (BAW+1)'(HDR_BYTES));
                        r_st    <= ST_OK;
                        r_state <= S_MARK_RD;
                    end else begin
                        r_run <= run_ext[14:0];
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_MARK_RD: r_state <= S_MARK;
                S_MARK: begin
                    if (r_pos + 1'b1 == r_end) begin
                        r_pos <= '0; r_state <= S_STAT_RD;
                    end else begin
                        r_pos <= r_pos + 1'b1; r_state <= S_MARK_RD;
                    end
                end
                S_FREE_RD: r_state <= S_FREE_CHK;
                S_FREE_CHK: begin
                    if (!r_blk_q[14]) begin
                        r_st <= ST_ILLEGAL; r_pos <= '0; r_state <= S_STAT_RD;
                    end else begin
                        r_st    <= ST_OK;
                        r_start <= (BAW+1)'(r_req.free_address) - (BAW+1)'(HDR_BYTES);
                        r_pos   <= (BAW+1)'(r_req.free_address) - (BAW+1)'(HDR_BYTES);
                        r_end   <= (BAW+1)'(r_req.free_address) + (BAW+1)'(r_blk_q[13:0]);
                        r_state <= S_UNMARK_RD;
                    end
                end
                S_UNMARK_RD: r_state <= S_UNMARK;
                S_UNMARK: begin
                    if (r_pos + 1'b1 == r_end || r_pos + 1'b1 == (BAW+1)'(POOL_BYTES)) begin
                        r_pos <= '0; r_state <= S_STAT_RD;
                    end else begin
                        r_pos <= r_pos + 1'b1; r_state <= S_UNMARK_RD;
                    end
                end
                S_STAT_RD: begin
                    r_pos <= '0; r_tot <= '0; r_big <= '0; r_small <= '0; r_srun <= '0;
                    r_state <= S_STAT;
                end
                S_STAT: begin
                    // data for r_pos word is in r_occ_q; advance to the next word
                    r_tot   <= r_tot + 17'(word_free);
                    r_srun  <= s_run;
                    r_big   <= s_big;
                    r_small <= s_small;
                    if (r_pos[BAW-1:4] == WAW'(WORDS - 1)) r_state <= S_OUT;
                    else r_pos <= r_pos + (BAW+1)'(WORD_BITS);
                end
                S_OUT: begin
                    // close a trailing run
                    r_rsp.status        <= r_st;
                    r_rsp.block_address <= r_baddr;
                    r_rsp.free_bytes    <= r_tot;
                    r_rsp.largest_free  <= (cand_run > r_big) ? cand_run : r_big;
                    r_rsp.smallest_free <= (cand_run != 17'd0 &&
                        (r_small == 17'd0 || cand_run < r_small)) ? cand_run : r_small;
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
    a_out_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_v) else $error("result lost");
    a_ok_alloc_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status != ST_OK) |-> o_rsp.data.block_address == 16'd0)
        else $error("address on failure");
`endif
endmodule
